// ===== rtl/dfiir_pkg.sv =====
// Shared types, constants and register codes for the direct form I IIR filter.
package dfiir_pkg;

    localparam int FF_TAPS_DEF = 4;
    localparam int FB_TAPS_DEF = 3;

    localparam int COEF_W = 18;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 24;
    localparam int FRAC_W = 15;
    localparam int IDX_W  = 3;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [IN_W-1:0]   sample_t;
    typedef logic signed [OUT_W-1:0]  result_t;

    localparam result_t OUT_MAX = 24'sh7FFFFF;
    localparam result_t OUT_MIN = 24'sh800000;

    localparam coef_t COEF_ONE = 18'sd32768;

    typedef enum logic [IDX_W-1:0] {
        REG_FF_COEF_0 = 3'd0,
        REG_FF_COEF_1 = 3'd1,
        REG_FF_COEF_2 = 3'd2,
        REG_FF_COEF_3 = 3'd3,
        REG_FB_COEF_1 = 3'd4,
        REG_FB_COEF_2 = 3'd5,
        REG_FB_COEF_3 = 3'd6
    } reg_idx_t;

    typedef struct packed {
        coef_t [3:0] ff;
        coef_t [3:1] fb;
    } coef_set_t;

    typedef struct packed {
        logic       filt_en;
        logic [3:1] fb_en;
    } tap_ctl_t;

    typedef struct packed {
        result_t sample;
        logic    clipped;
    } mac_res_t;

endpackage

// ===== rtl/direct_form_iir_filter_core.sv =====
// Top level of the direct form I IIR filter: handshakes, histories and result register.
//
// Direct form I IIR filter for a stream of signed 16-bit audio samples. Each
// request on the s_ channel yields exactly one 24-bit result on the m_ channel,
// in order. The block takes one sample per clock cycle when the output side
// keeps up; each sample passes the input register, then the result register.
// All taps are summed in one pass between those two registers, and the
// feedback history is written at the same edge as the result register, so the
// next sample takes it into its sum. The first FF_TAPS+1 samples after reset
// pass through sign-extended, with clipped low. After that the output is the
// Q2.15 sum of feed-forward and feedback taps, rounded half up, saturated to
// 24 bits and flagged on m_tuser when saturated. Feedback taps phase in one
// by one: tap i joins after FB_TAPS+i filtered outputs. Coefficients are
// written on the cfg_ channel (index 0..3 ff_coef_0..3, 4..6 fb_coef_1..3,
// others ignored) and must only change while the filter is idle. cfg_ready
// is always high. Reset is synchronous, active low, and restores unity gain.
module direct_form_iir_filter_core
    import dfiir_pkg::*;
#(
    parameter int FF_TAPS = FF_TAPS_DEF,  // 1..4
    parameter int FB_TAPS = FB_TAPS_DEF   // 0..3
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] sample_in

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [23:0] sample_out
    output logic [0:0]           m_tuser,   // [0] clipped

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    localparam int FILT_START = FF_TAPS + 1;
    localparam int FB_START   = FF_TAPS + 1 + FB_TAPS;
    localparam int SEEN_MAX   = FF_TAPS + 1 + 2 * FB_TAPS;
    localparam int SEEN_W     = $clog2(SEEN_MAX + 1);

    // input stage
    logic             in_valid_reg;
    sample_t          in_sample_reg;

    // result stage
    logic             out_valid_reg;
    result_t          out_sample_reg;
    logic             out_clip_reg;

    // filter state
    sample_t [2:0]    in_hist_reg;
    result_t [2:0]    out_hist_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;

    coef_set_t        coefs;
    tap_ctl_t         ctl;
    mac_res_t         res;
    logic             adv;       // input stage moves into result stage
    logic             s_take;

    assign cfg_ready = 1'b1;

    dfiir_coef_regs u_coef_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    // tap enables follow the count of samples already processed
    always_comb begin
        ctl.filt_en = (seen_reg >= SEEN_W'(FILT_START));
        for (int i = 1; i < 4; i++) begin
            ctl.fb_en[i] = (i <= FB_TAPS) && (seen_reg >= SEEN_W'(FB_START + i));
        end
    end

    dfiir_mac #(
        .FF_TAPS (FF_TAPS)
    ) u_mac (
        .sample   (in_sample_reg),
        .in_hist  (in_hist_reg),
        .out_hist (out_hist_reg),
        .coefs    (coefs),
        .ctl      (ctl),
        .res      (res)
    );

    // result register frees up when empty or being drained
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_take   = s_tvalid && s_tready;

    assign seen_next = (seen_reg == SEEN_W'(SEEN_MAX)) ? seen_reg : seen_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_hist_reg   <= '0;
            out_hist_reg  <= '0;
            seen_reg      <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end

            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (adv) begin
                in_hist_reg  <= {in_hist_reg[1:0], in_sample_reg};
                out_hist_reg <= {out_hist_reg[1:0], res.sample};
                seen_reg     <= seen_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_sample_reg <= sample_t'(s_tdata);
        end
        if (adv) begin
            out_sample_reg <= res.sample;
            out_clip_reg   <= res.clipped;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_sample_reg;
    assign m_tuser[0] = out_clip_reg;

`ifndef SYNTHESIS
    // a clipped result always sits on a rail
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == OUT_MAX) || (m_tdata == OUT_MIN))
        else $error("clipped result not at saturation rail");

    // feedback history holds exactly the result just issued
    a_hist_match: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_hist_reg[0] == out_sample_reg)
        else $error("output history out of step with result register");

    // pass-through phase never flags clipping
    a_pass_noclip: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !ctl.filt_en |=> !m_tuser[0] && (m_tdata == $past(OUT_W'(in_sample_reg))))
        else $error("pass-through sample altered");

    // sample counter stays within its saturation point
    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= SEEN_W'(SEEN_MAX))
        else $error("sample counter past its limit");

    // a held result is not overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");
`endif

endmodule

// ===== rtl/dfiir_coef_regs.sv =====
// Coefficient register file written through the configuration channel.
module dfiir_coef_regs
    import dfiir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    output coef_set_t            coefs
);

    // unity gain on the current input, every other tap off
    localparam coef_set_t COEFS_INIT = '{
        ff: {coef_t'(0), coef_t'(0), coef_t'(0), COEF_ONE},
        fb: '0
    };

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    always_comb begin
        coefs_next = coefs_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_FF_COEF_0: coefs_next.ff[0] = coef_t'(cfg_data);
                REG_FF_COEF_1: coefs_next.ff[1] = coef_t'(cfg_data);
                REG_FF_COEF_2: coefs_next.ff[2] = coef_t'(cfg_data);
                REG_FF_COEF_3: coefs_next.ff[3] = coef_t'(cfg_data);
                REG_FB_COEF_1: coefs_next.fb[1] = coef_t'(cfg_data);
                REG_FB_COEF_2: coefs_next.fb[2] = coef_t'(cfg_data);
                REG_FB_COEF_3: coefs_next.fb[3] = coef_t'(cfg_data);
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg <= COEFS_INIT;
        end else begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

// ===== rtl/dfiir_mac.sv =====
// Multiply-accumulate, rounding and saturation for one sample, or pass-through.
module dfiir_mac
    import dfiir_pkg::*;
#(
    parameter int FF_TAPS = FF_TAPS_DEF
) (
    input  sample_t          sample,
    input  sample_t [2:0]    in_hist,   // [0] newest
    input  result_t [2:0]    out_hist,  // [0] newest
    input  coef_set_t        coefs,
    input  tap_ctl_t         ctl,
    output mac_res_t         res
);

    localparam int FFP_W = COEF_W + IN_W;
    localparam int FBP_W = COEF_W + OUT_W;
    localparam int ACC_W = FBP_W + 3;

    logic signed [FFP_W-1:0] ff_prod [4];
    logic signed [FBP_W-1:0] fb_prod [1:3];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd;

    always_comb begin
        ff_prod[0] = $signed(coefs.ff[0]) * sample;
        for (int i = 1; i < 4; i++) begin
            ff_prod[i] = $signed(coefs.ff[i]) * in_hist[i-1];
        end
        for (int i = 1; i < 4; i++) begin
            fb_prod[i] = $signed(coefs.fb[i]) * out_hist[i-1];
        end

        acc = ACC_W'(ff_prod[0]);
        for (int i = 1; i < 4; i++) begin
            if (i < FF_TAPS) begin
                acc = acc + ACC_W'(ff_prod[i]);
            end
        end
        for (int i = 1; i < 4; i++) begin
            if (ctl.fb_en[i]) begin
                acc = acc + ACC_W'(fb_prod[i]);
            end
        end

        // round half up, then drop the fraction
        rnd = (acc + ACC_W'(1 << (FRAC_W - 1))) >>> FRAC_W;

        if (!ctl.filt_en) begin
            res.sample  = OUT_W'(sample);
            res.clipped = 1'b0;
        end else if (rnd > ACC_W'(OUT_MAX)) begin
            res.sample  = OUT_MAX;
            res.clipped = 1'b1;
        end else if (rnd < ACC_W'(OUT_MIN)) begin
            res.sample  = OUT_MIN;
            res.clipped = 1'b1;
        end else begin
            res.sample  = OUT_W'(rnd);
            res.clipped = 1'b0;
        end
    end

endmodule

// ===== tb/sv/direct_form_iir_filter_core_tb.sv =====
// Self-checking testbench for the direct form I IIR filter core.
`timescale 1ns / 1ps

module direct_form_iir_filter_core_tb;
    import dfiir_pkg::*;

    localparam int FF_N = FF_TAPS_DEF;
    localparam int FB_N = FB_TAPS_DEF;
    // Sample counter saturates once every feedback tap has phased in.
    localparam int SEEN_LIMIT = FF_N + 1 + 2 * FB_N;

    localparam int RANDOM_ITEMS = 900;
    localparam int SETTLE       = 6;       // idle wait after the queues have drained
    localparam int LONG_HOLD    = 150;     // receiver back-pressure stretch
    localparam int HOLD_EVERY   = 300;     // results between long holds
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;

    // Index past the last register: the core must drop the write.
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    localparam coef_t   COEF_MAX   = 18'sh1FFFF;
    localparam coef_t   COEF_MIN   = 18'sh20000;
    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    typedef enum int {SET_TAME, SET_WILD, SET_EDGE, SET_RAIL_HI, SET_RAIL_LO} coef_style_t;
    typedef enum logic [1:0] {RX_OPEN, RX_CADENCE, RX_COIN, RX_SPARSE} rx_mode_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;   // [15:0] sample_in
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;          // [23:0] sample_out
    logic [0:0]        m_tuser;          // [0] clipped
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [COEF_W-1:0] cfg_data  = '0;

    direct_form_iir_filter_core #(
        .FF_TAPS(FF_N),
        .FB_TAPS(FB_N)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Filter predictor: own copy of coefficients and histories
    // ------------------------------------------------------------------
    coef_t    ff_c [4]   = '{COEF_ONE, '0, '0, '0};
    coef_t    fb_c [1:3] = '{'0, '0, '0};
    sample_t  in_hist [3]  = '{'0, '0, '0};   // newest first
    result_t  out_hist [3] = '{'0, '0, '0};   // saturated outputs, newest first
    int       seen_cnt = 0;

    sample_t  pending_samples [$];   // samples waiting to be offered
    mac_res_t filtered_due [$];      // predicted outputs, oldest first

    int mismatches    = 0;
    int results_taken = 0;

    // Appends one sample to the end of the send queue.
    function automatic void queue_sample(input sample_t x);
        pending_samples.insert(pending_samples.size(), x);
    endfunction

    // Computes the filter output for one accepted sample and advances the state.
    function automatic void predict_filtered(input sample_t x);
        longint   acc;
        longint   y;
        int       k;
        int       taps_on;
        mac_res_t res;
        res.clipped = 1'b0;
        if (seen_cnt < FF_N + 1) begin
            // pass-through phase right after reset
            y = longint'(x);
        end else begin
            k = seen_cnt - (FF_N + 1);
            taps_on = 0;
            if (k > FB_N) taps_on = (k - FB_N > FB_N) ? FB_N : k - FB_N;
            acc = longint'(ff_c[0]) * longint'(x);
            for (int i = 1; i < FF_N; i++)
                acc += longint'(ff_c[i]) * longint'(in_hist[i-1]);
            for (int i = 1; i <= taps_on; i++)
                acc += longint'(fb_c[i]) * longint'(out_hist[i-1]);
            // round half up, then arithmetic shift out the Q.15 fraction
            y = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
            if (y > longint'(OUT_MAX)) begin
                y = longint'(OUT_MAX);
                res.clipped = 1'b1;
            end else if (y < longint'(OUT_MIN)) begin
                y = longint'(OUT_MIN);
                res.clipped = 1'b1;
            end
        end
        res.sample = y[OUT_W-1:0];
        in_hist[2]  = in_hist[1];
        in_hist[1]  = in_hist[0];
        in_hist[0]  = x;
        out_hist[2] = out_hist[1];
        out_hist[1] = out_hist[0];
        out_hist[0] = res.sample;   // feedback uses the clipped value
        if (seen_cnt < SEEN_LIMIT) seen_cnt++;
        filtered_due.insert(filtered_due.size(), res);
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps in between.
    // Valid holds with stable data until the request is taken.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_filtered(sample_t'(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        // a quarter of the bursts run straight into the next
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: segments of different stall patterns, plus long holds
    // while the sender still has plenty queued so the core backs up.
    // ------------------------------------------------------------------
    int       stall_left = 0;
    int       holds_done = 0;
    int       seg_left   = 0;
    rx_mode_t seg_mode   = RX_OPEN;
    logic [1:0] cadence  = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (holds_done < 2 && results_taken >= (holds_done + 1) * HOLD_EVERY
                     && pending_samples.size() >= 20) begin
            stall_left <= LONG_HOLD;
            holds_done <= holds_done + 1;
            m_tready   <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_mode <= rx_mode_t'($urandom_range(0, 3));
                seg_left <= $urandom_range(8, 60);
            end else begin
                seg_left <= seg_left - 1;
            end
            cadence <= cadence + 1'b1;
            case (seg_mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_CADENCE: m_tready <= (cadence != 2'd0);
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                default:    m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        mac_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_taken <= results_taken + 1;
            if (filtered_due.size() == 0) begin
                note_mismatch($sformatf("result %h with none pending", m_tdata));
            end else begin
                want = filtered_due.pop_front();
                if (m_tdata !== want.sample)
                    note_mismatch($sformatf("sample_out %h, want %h", m_tdata, want.sample));
                if (m_tuser[0] !== want.clipped)
                    note_mismatch($sformatf("clipped %b, want %b (sample %h)",
                                            m_tuser[0], want.clipped, want.sample));
            end
        end
    end

    // Watchdog on total run length.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One coefficient write request; the predictor copy follows once taken.
    task automatic coef_write(input logic [IDX_W-1:0] idx, input coef_t value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= REG_FF_COEF_3)
            ff_c[idx] = value;
        else if (idx <= REG_FB_COEF_3)
            fb_c[idx - REG_FB_COEF_1 + 1] = value;
    endtask

    // Wait until every queued sample went in and every result came back.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_tvalid || filtered_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic sample_t draw_sample();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1:       return sample_t'(int'($urandom_range(0, 127)) - 64);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_t draw_coef(input coef_style_t style, input int r);
        case (style)
            SET_TAME: begin
                // feedback kept small so the loop stays mostly stable
                if (r >= REG_FB_COEF_1) return coef_t'(int'($urandom_range(0, 12000)) - 6000);
                return coef_t'(int'($urandom_range(0, 32768)) - 16384);
            end
            SET_WILD:    return coef_t'($urandom);
            SET_RAIL_HI: return COEF_MAX;
            SET_RAIL_LO: return COEF_MIN;
            default: begin
                case ($urandom_range(0, 5))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return '0;
                    3:       return '1;
                    4:       return coef_t'(1);
                    default: return COEF_ONE;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          random_items;
        int          phase_no;
        int          n;
        coef_style_t style;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset coefficients: five pass-through samples at the extremes,
        // then three more through the unity-gain default.
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        queue_sample(16'sd0);
        queue_sample(-16'sd1);
        queue_sample(16'sd1);
        queue_sample(16'sd21845);
        queue_sample(-16'sd21846);
        queue_sample(16'sd12345);
        wait_drained();

        // Moderate taps with distinct feedback values so the tap ramp-in
        // shows step by step; the spare index must be dropped.
        coef_write(REG_FF_COEF_0, 18'sd16384);
        coef_write(REG_FF_COEF_1, 18'sd8192);
        coef_write(REG_FF_COEF_2, -18'sd8192);
        coef_write(REG_FF_COEF_3, 18'sd4096);
        coef_write(REG_FB_COEF_1, 18'sd16384);
        coef_write(REG_FB_COEF_2, -18'sd8192);
        coef_write(REG_FB_COEF_3, 18'sd4096);
        coef_write(REG_SPARE, COEF_MAX);
        queue_sample(16'sd30000);
        queue_sample(-16'sd30000);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(16'sd1000);
        queue_sample(-16'sd1);
        wait_drained();

        // Full-scale gains with alternating-sign feedback: the output swings
        // into both rails and the clipped values feed back.
        for (int r = REG_FF_COEF_0; r <= REG_FF_COEF_3; r++) coef_write(IDX_W'(r), COEF_MAX);
        coef_write(REG_FB_COEF_1, COEF_MIN);
        coef_write(REG_FB_COEF_2, COEF_MAX);
        coef_write(REG_FB_COEF_3, COEF_MIN);
        repeat (5) queue_sample(SAMPLE_MAX);
        repeat (5) queue_sample(SAMPLE_MIN);
        wait_drained();

        // Random phases, each under a fresh coefficient set; the first two
        // pin every coefficient to one rail.
        random_items = 0;
        phase_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase_no == 0)
                style = SET_RAIL_HI;
            else if (phase_no == 1)
                style = SET_RAIL_LO;
            else
                case ($urandom_range(0, 7))
                    5, 6:    style = SET_WILD;
                    7:       style = SET_EDGE;
                    default: style = SET_TAME;
                endcase
            if ($urandom_range(0, 2) == 0) coef_write(REG_SPARE, coef_t'($urandom));
            for (int r = REG_FF_COEF_0; r <= REG_FB_COEF_3; r++)
                coef_write(IDX_W'(r), draw_coef(style, r));
            n = $urandom_range(40, 110);
            repeat (n) queue_sample(draw_sample());
            random_items += n;
            phase_no++;
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
